[rtl/core/assert_macros.svh]
// Assertion macros shared by the scan-out RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a same-cycle implication under a synchronous active-low reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check an implication that lands in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/rgbpwm_pkg.sv]
// Shared types, constants and tables for the RGB bit-plane PWM scan-out.
// No dependencies.
package rgbpwm_pkg;

    localparam int PLANES      = 15;
    localparam int LED_COUNT   = 16;
    localparam int FRAME_BYTES = 6;

    localparam int PLANE_BITS = 48;
    localparam int POS_W      = 6;
    localparam int LED_W      = 4;
    localparam int LEVEL_W    = 4;
    localparam int REQ_W      = 2;
    localparam int REPEAT_W   = 6;
    localparam int PLANE_W    = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int BYTE_W     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    // Request codes carried in the input tuser.
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

    // Bit position of red, green, blue for each LED (byte*8 + bit).
    localparam logic [POS_W-1:0] CHAN_POS [16][3] = '{
        '{6'd25, 6'd24, 6'd23},
        '{6'd22, 6'd21, 6'd20},
        '{6'd19, 6'd18, 6'd17},
        '{6'd16, 6'd15, 6'd14},
        '{6'd13, 6'd12, 6'd11},
        '{6'd10, 6'd9,  6'd8 },
        '{6'd7,  6'd6,  6'd5 },
        '{6'd4,  6'd3,  6'd2 },
        '{6'd47, 6'd1,  6'd0 },
        '{6'd44, 6'd45, 6'd46},
        '{6'd41, 6'd42, 6'd43},
        '{6'd38, 6'd39, 6'd40},
        '{6'd37, 6'd36, 6'd35},
        '{6'd34, 6'd33, 6'd32},
        '{6'd29, 6'd30, 6'd31},
        '{6'd26, 6'd27, 6'd28}
    };

    // Extra repeats of each plane beyond its first pass.
    localparam logic [REPEAT_W-1:0] PLANE_WEIGHT [15] = '{
        6'd0, 6'd0, 6'd0, 6'd0, 6'd1, 6'd2, 6'd4, 6'd6,
        6'd10, 6'd14, 6'd20, 6'd26, 6'd34, 6'd43, 6'd54
    };

    // Plane update from the item stage to the plane store.
    typedef struct packed {
        logic               set;
        logic               clear;
        logic [LED_W-1:0]   led;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } t_plane_cmd;

    // Current scan position.
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [BYTE_W-1:0]  byte_pos;
    } t_scan_pos;

endpackage

[rtl/core/rgbpwm_plane_store.sv]
// Thermometer-coded bit-plane store with set, clear and one read port.
// Depends on rgbpwm_pkg.
module rgbpwm_plane_store
    import rgbpwm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_plane_cmd            i_cmd,
    input  logic [PLANE_W-1:0]    i_rd_plane,
    output logic [PLANE_BITS-1:0] o_rd_data
);

    logic [PLANE_BITS-1:0] r_plane [PLANES];
    logic [PLANE_BITS-1:0] n_plane [PLANES];
    logic [LEVEL_W:0]      lvl_r, lvl_g, lvl_b;
    logic                  led_ok;

    // Saturate a level at the plane count.
    function automatic logic [LEVEL_W:0] sat_level(input logic [LEVEL_W-1:0] lvl);
        logic [LEVEL_W:0] wide;
        wide = {1'b0, lvl};
        return (wide > (LEVEL_W+1)'(PLANES)) ? (LEVEL_W+1)'(PLANES) : wide;
    endfunction

    assign lvl_r  = sat_level(i_cmd.red);
    assign lvl_g  = sat_level(i_cmd.green);
    assign lvl_b  = sat_level(i_cmd.blue);
    assign led_ok = ({1'b0, i_cmd.led} < (LED_W+1)'(LED_COUNT));

    always_comb begin
        for (int p = 0; p < PLANES; p++) begin
            n_plane[p] = r_plane[p];
            if (i_cmd.clear) begin
                n_plane[p] = '0;
            end else if (i_cmd.set && led_ok) begin
                n_plane[p][CHAN_POS[i_cmd.led][0]] = (lvl_r > (LEVEL_W+1)'(p));
                n_plane[p][CHAN_POS[i_cmd.led][1]] = (lvl_g > (LEVEL_W+1)'(p));
                n_plane[p][CHAN_POS[i_cmd.led][2]] = (lvl_b > (LEVEL_W+1)'(p));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < PLANES; p++) begin
            if (!i_rst_n) begin
                r_plane[p] <= '0;
            end else begin
                r_plane[p] <= n_plane[p];
            end
        end
    end

    assign o_rd_data = r_plane[i_rd_plane];

endmodule

[rtl/core/rgbpwm_scan_ctrl.sv]
// Scan sequencer: byte position, plane index and plane repeat counter.
// Depends on rgbpwm_pkg.
module rgbpwm_scan_ctrl
    import rgbpwm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_tick,
    output t_scan_pos o_pos
);

    logic [PLANE_W-1:0]  r_plane, n_plane;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic [REPEAT_W-1:0] r_repeat, n_repeat;

    always_comb begin
        n_plane  = r_plane;
        n_byte   = r_byte;
        n_repeat = r_repeat;
        if (i_tick) begin
            if (r_byte == BYTE_W'(FRAME_BYTES - 1)) begin
                n_byte = '0;
                // Move to the next plane once this one has gone out weight+1 times.
                if (r_repeat == PLANE_WEIGHT[r_plane]) begin
                    n_repeat = '0;
                    n_plane  = (r_plane == PLANE_W'(PLANES - 1)) ? '0 : r_plane + 1'b1;
                end else begin
                    n_repeat = r_repeat + 1'b1;
                end
            end else begin
                n_byte = r_byte + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane  <= '0;
            r_byte   <= '0;
            r_repeat <= '0;
        end else begin
            r_plane  <= n_plane;
            r_byte   <= n_byte;
            r_repeat <= n_repeat;
        end
    end

    assign o_pos.plane    = r_plane;
    assign o_pos.byte_pos = r_byte;

endmodule

[rtl/core/rgb_led_bitplane_pwm_scanout_top.sv]
// Top level of the RGB LED bit-plane PWM scan-out.
// Depends on rgbpwm_pkg, rgbpwm_plane_store, rgbpwm_scan_ctrl, assert_macros.svh.
//
// Usage:
//   Input stream (s_axis): one word per request. tuser carries the request
//   kind (set LED colour, clear all planes, byte-slot tick); tdata carries the
//   LED index and the three colour levels. Set and clear words update the
//   15 thermometer-coded bit planes and return nothing. Each tick returns one
//   word on the output stream (m_axis) while enable is high: tdata is the
//   next byte to shift into the driver chain, tuser flags a latch pulse
//   before byte 0 of a frame. Plane p is sent weight[p]+1 times in a row.
//   Config channel: one bit, enable. Write it only while the block is idle.
//   A word in the input register is processed once the result register is
//   free or draining; its result, if any, is written there. Throughput: one
//   word per cycle unless m_axis stalls, set by the single input register
//   feeding the single result register. Stall: while a result waits, one
//   more word is held in the input register; s_axis tready drops only when both registers are full.
//   Reset: planes cleared, scan at plane 0 byte 0, enable set to 1.
`include "assert_macros.svh"

module rgb_led_bitplane_pwm_scanout_top
    import rgbpwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // led_index[3:0], red_level[7:4],
                                         // green_level[11:8], blue_level[15:12]
    input  logic [1:0]  i_s_axis_tuser,  // req_type[1:0]
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // shift_byte[7:0]
    output logic [0:0]  o_m_axis_tuser,  // latch_before[0]
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data       // enable[0]
);

    // Input register
    logic               r_in_valid;
    logic [REQ_W-1:0]   r_in_req;
    logic [LED_W-1:0]   r_in_led;
    logic [LEVEL_W-1:0] r_in_red, r_in_green, r_in_blue;

    // Result register
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_latch;

    logic               r_enable;

    logic                  advance;
    logic                  tick;
    logic                  first_byte;
    t_plane_cmd            plane_cmd;
    t_scan_pos             scan_pos;
    logic [PLANE_BITS-1:0] plane_data;
    logic [7:0]            sel_byte;

    // Process the held word when the result register is free or draining.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign tick            = advance && (r_in_req == REQ_TICK) && r_enable;

    assign plane_cmd.set   = advance && (r_in_req == REQ_SET);
    assign plane_cmd.clear = advance && (r_in_req == REQ_CLEAR);
    assign plane_cmd.led   = r_in_led;
    assign plane_cmd.red   = r_in_red;
    assign plane_cmd.green = r_in_green;
    assign plane_cmd.blue  = r_in_blue;

    rgbpwm_plane_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (plane_cmd),
        .i_rd_plane (scan_pos.plane),
        .o_rd_data  (plane_data)
    );

    rgbpwm_scan_ctrl u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick),
        .o_pos   (scan_pos)
    );

    // Pick byte k of the current plane: bits 8k+7..8k.
    assign sel_byte   = plane_data[8*scan_pos.byte_pos +: 8];
    assign first_byte = (scan_pos.byte_pos == '0);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b1;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (tick) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data[0];
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_req   <= i_s_axis_tuser;
            r_in_led   <= i_s_axis_tdata[3:0];
            r_in_red   <= i_s_axis_tdata[7:4];
            r_in_green <= i_s_axis_tdata[11:8];
            r_in_blue  <= i_s_axis_tdata[15:12];
        end
        if (tick) begin
            r_out_byte  <= sel_byte;
            r_out_latch <= first_byte;
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_byte;
    assign o_m_axis_tuser[0] = r_out_latch;

    // A processed enabled tick always shows a result next cycle.
    `ASSERT_NEXT(a_tick_gives_word, i_clk, i_rst_n, tick, r_out_valid)
    // A tick at byte 0 carries the latch flag.
    `ASSERT_NEXT(a_latch_on_byte0, i_clk, i_rst_n, tick && first_byte, r_out_latch)
    // Input stalls only when the result register is full and the output is stalled.
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !o_s_axis_tready, r_out_valid && !i_m_axis_tready)
    // Scan position stays inside the frame and plane range.
    `ASSERT_IMPL(a_byte_range, i_clk, i_rst_n, 1'b1, scan_pos.byte_pos < BYTE_W'(FRAME_BYTES))
    `ASSERT_IMPL(a_plane_range, i_clk, i_rst_n, 1'b1, scan_pos.plane < PLANE_W'(PLANES))

endmodule
